FILE: hdl/assert_macros.svh
// Assertion macros shared by the palette lookup pixel doubler modules.
// Each macro expects a clock named clock and a synchronous reset named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks a property on every clock edge outside reset.
`define PLPD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Checks that a condition implies another one on the following clock edge.
`define PLPD_ASSERT_NEXT(label, cond, nxt, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) \
      else $error(msg);
`else
`define PLPD_ASSERT(label, prop, msg)
`define PLPD_ASSERT_NEXT(label, cond, nxt, msg)
`endif
`endif

FILE: hdl/plpd_pkg.sv
// Package of the palette lookup pixel doubler: widths, codes and shared types.
// Used by the channel interfaces and by every module of the block.
`default_nettype none

package plpd_pkg;

   // Source frame and palette sizes.
   localparam int SRC_WIDTH       = 320;
   localparam int SRC_HEIGHT      = 240;
   localparam int PALETTE_ENTRIES = 4096;

   // Field widths.
   localparam int INDEX_W   = 12;
   localparam int COLOR_W   = 15;
   localparam int CHAN_W    = 5;
   localparam int BYTE_W    = 8;
   localparam int COORD_W   = 10;
   localparam int COL_W     = 9;
   localparam int ROW_W     = 8;
   localparam int SUB_W     = 2;
   localparam int ADDR_W    = $clog2(PALETTE_ENTRIES);

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = COORD_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_X      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Y      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWAP_RED_BLUE = 2'd2;

   // Item modes.
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_PIXEL = 1'b1;

   // Last column and row of the source frame.
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(SRC_WIDTH - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SRC_HEIGHT - 1);

   // Palette access for one transaction.
   typedef struct packed {
      logic               wr_en;
      logic               rd_en;
      logic [INDEX_W-1:0] index;
      logic [COLOR_W-1:0] color;
   } pal_req_type;

   // One looked-up pixel handed to the output stage.
   typedef struct packed {
      logic [COORD_W-1:0] base_x;
      logic [COORD_W-1:0] base_y;
      logic [COLOR_W-1:0] color;
      logic               swap;
   } blk_type;

endpackage

`default_nettype wire

FILE: hdl/plpd_req_if.sv
// Input channel of the palette lookup pixel doubler: palette writes and pixel pens.
// Depends on plpd_pkg for the field widths.
`default_nettype none

interface plpd_req_if;
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic [plpd_pkg::INDEX_W-1:0]  index;
   logic [plpd_pkg::COLOR_W-1:0]  color;

   modport source (output valid, mode, index, color, input ready);
   modport sink (input valid, mode, index, color, output ready);
endinterface

`default_nettype wire

FILE: hdl/plpd_rsp_if.sv
// Result channel of the palette lookup pixel doubler: a 2x2 block of four output pixels per pixel pen.
// Depends on plpd_pkg for the field widths.
`default_nettype none

interface plpd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [plpd_pkg::COORD_W-1:0]  out_x;
   logic [plpd_pkg::COORD_W-1:0]  out_y;
   logic [plpd_pkg::BYTE_W-1:0]   first_byte;
   logic [plpd_pkg::BYTE_W-1:0]   second_byte;
   logic [plpd_pkg::BYTE_W-1:0]   third_byte;
   logic                          last;

   modport source (output valid, out_x, out_y, first_byte, second_byte, third_byte, last,
                   input ready);
   modport sink (input valid, out_x, out_y, first_byte, second_byte, third_byte, last,
                 output ready);
endinterface

`default_nettype wire

FILE: hdl/plpd_csr_if.sv
// Configuration write channel of the palette lookup pixel doubler.
// Depends on plpd_pkg for the index and data widths.
`default_nettype none

interface plpd_csr_if;
   logic                             valid;
   logic                             ready;
   logic [plpd_pkg::CSR_INDEX_W-1:0] index;
   logic [plpd_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/plpd_palette.sv
// Palette store with registered read and a clearing pass after reset.
// Depends on plpd_pkg for sizes and the pal_req_type access struct.
`default_nettype none

module plpd_palette (
   input  logic                         clock,
   input  logic                         reset,
   input  plpd_pkg::pal_req_type        pal_req,
   output logic [plpd_pkg::COLOR_W-1:0] rd_color,
   output logic                         clearing
);

   localparam logic [plpd_pkg::ADDR_W-1:0] LAST_ADDR =
      plpd_pkg::ADDR_W'(plpd_pkg::PALETTE_ENTRIES - 1);
   localparam logic [plpd_pkg::INDEX_W:0] PEN_LIMIT =
      (plpd_pkg::INDEX_W + 1)'(plpd_pkg::PALETTE_ENTRIES);

   logic [plpd_pkg::COLOR_W-1:0] mem [plpd_pkg::PALETTE_ENTRIES];

   logic                          clearing_ff, clearing_in;
   logic [plpd_pkg::ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [plpd_pkg::COLOR_W-1:0]  rd_data_ff;
   logic                          rd_zero_ff;
   logic                          in_range;
   logic [plpd_pkg::ADDR_W-1:0]   addr;
   logic                          wr_en;
   logic [plpd_pkg::ADDR_W-1:0]   wr_addr;
   logic [plpd_pkg::COLOR_W-1:0]  wr_data;

   // Pens beyond the palette are ignored on write and read as zero.
   always_comb begin
      in_range = {1'b0, pal_req.index} < PEN_LIMIT;
      addr     = pal_req.index[plpd_pkg::ADDR_W-1:0];
   end

   // The clearing pass owns the write port until every entry holds zero.
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ADDR) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Single write port, shared by the clearing pass and palette writes.
   always_comb begin
      wr_en   = clearing_ff || (pal_req.wr_en && in_range);
      wr_addr = clearing_ff ? clr_addr_ff : addr;
      wr_data = clearing_ff ? '0 : pal_req.color;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (pal_req.rd_en) begin
         rd_data_ff <= mem[addr];
         rd_zero_ff <= !in_range;
      end
   end

   assign rd_color = rd_zero_ff ? '0 : rd_data_ff;
   assign clearing = clearing_ff;

endmodule

`default_nettype wire

FILE: hdl/plpd_emit.sv
// Output stage: widens one looked-up colour and sends the four pixels of its 2x2 block.
// Depends on plpd_pkg, plpd_rsp_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module plpd_emit (
   input  logic                clock,
   input  logic                reset,
   input  plpd_pkg::blk_type   blk,
   input  logic                load_en,
   output logic                can_load,
   plpd_rsp_if.source          rsp_bus
);

   localparam logic [plpd_pkg::SUB_W-1:0] LAST_SUB = 2'd3;

   logic                          valid_ff, valid_in;
   logic [plpd_pkg::SUB_W-1:0]    cnt_ff, cnt_in;
   logic [plpd_pkg::COORD_W-1:0]  x_ff, y_ff;
   logic [plpd_pkg::BYTE_W-1:0]   first_ff, second_ff, third_ff;
   logic [plpd_pkg::BYTE_W-1:0]   red, green, blue;
   logic                          fire, at_last;

   // Widens a 5-bit channel to 8 bits by repeating its top bits.
   function automatic logic [plpd_pkg::BYTE_W-1:0] widen5(
      input logic [plpd_pkg::CHAN_W-1:0] v
   );
      return {v, v[plpd_pkg::CHAN_W-1:plpd_pkg::CHAN_W-3]};
   endfunction

   always_comb begin
      red   = widen5(blk.color[14:10]);
      green = widen5(blk.color[9:5]);
      blue  = widen5(blk.color[4:0]);
   end

   // The stage frees up when idle or when the last pixel of its block leaves.
   always_comb begin
      fire     = valid_ff && rsp_bus.ready;
      at_last  = cnt_ff == LAST_SUB;
      can_load = !valid_ff || (fire && at_last);
   end

   always_comb begin
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      if (fire) begin
         if (at_last) begin
            valid_in = 1'b0;
            cnt_in   = '0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
      if (load_en) begin
         valid_in = 1'b1;
         cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Block payload, captured when a new pixel enters the stage.
   always_ff @(posedge clock) begin
      if (load_en) begin
         x_ff      <= blk.base_x;
         y_ff      <= blk.base_y;
         first_ff  <= blk.swap ? blue : red;
         second_ff <= green;
         third_ff  <= blk.swap ? red : blue;
      end
   end

   // Pixel order is top-left, top-right, bottom-left, bottom-right.
   always_comb begin
      rsp_bus.valid       = valid_ff;
      rsp_bus.out_x       = x_ff + plpd_pkg::COORD_W'(cnt_ff[0]);
      rsp_bus.out_y       = y_ff + plpd_pkg::COORD_W'(cnt_ff[1]);
      rsp_bus.first_byte  = first_ff;
      rsp_bus.second_byte = second_ff;
      rsp_bus.third_byte  = third_ff;
      rsp_bus.last        = at_last;
   end

   `PLPD_ASSERT(a_load_only_when_free, load_en |-> can_load, "block loaded over a busy stage")
   `PLPD_ASSERT(a_idle_count_zero, !valid_ff |-> cnt_ff == '0, "pixel count not zero when idle")
   `PLPD_ASSERT_NEXT(a_stall_holds_count, valid_ff && !rsp_bus.ready,
                     valid_ff && cnt_ff == $past(cnt_ff), "stalled block lost its position")

endmodule

`default_nettype wire

FILE: hdl/palette_lookup_pixel_doubler.sv
// Top level of the palette lookup pixel doubler: configuration, source counters,
// lookup stage and flow control. Depends on plpd_pkg, the channel interfaces,
// plpd_palette, plpd_emit and assert_macros.svh.
//
//   channel   direction  carries
//   req_bus   in         mode, index, color (palette write or pixel pen)
//   rsp_bus   out        out_x, out_y, first_byte, second_byte, third_byte, last
//   csr_bus   in         index, data (origin_x, origin_y, swap_red_blue)
//
// For each pixel pen the output stage sends its 2x2 block, one pixel per cycle while
// rsp_bus.ready is high. A palette write produces no result. The first pixel of a block
// passes through the palette read register and is then loaded into the output stage.
// After reset a clearing pass zeroes the palette; req_bus.ready stays low until it ends,
// while csr_bus writes are taken at once.
// A stall on rsp_bus holds the output stage; the lookup register then fills and
// req_bus.ready drops until the block drains.
`default_nettype none
`include "assert_macros.svh"

module palette_lookup_pixel_doubler (
   input  logic         clock,
   input  logic         reset,
   plpd_req_if.sink     req_bus,
   plpd_rsp_if.source   rsp_bus,
   plpd_csr_if.sink     csr_bus
);

   logic [plpd_pkg::COORD_W-1:0]  origin_x_ff, origin_y_ff;
   logic                          swap_ff;
   logic [plpd_pkg::COL_W-1:0]    col_ff, col_in;
   logic [plpd_pkg::ROW_W-1:0]    row_ff, row_in;
   logic                          s1_valid_ff, s1_valid_in;
   logic [plpd_pkg::COORD_W-1:0]  s1_bx_ff, s1_by_ff;
   logic                          req_fire, pix_fire, wr_fire, csr_fire, s1_move;
   logic                          clearing, emit_can_load;
   logic [plpd_pkg::COLOR_W-1:0]  rd_color;
   plpd_pkg::pal_req_type         pal_req;
   plpd_pkg::blk_type             blk;

   // Handshakes.
   always_comb begin
      s1_move       = s1_valid_ff && emit_can_load;
      req_bus.ready = !clearing && (!s1_valid_ff || emit_can_load);
      csr_bus.ready = 1'b1;
      req_fire      = req_bus.valid && req_bus.ready;
      pix_fire      = req_fire && (req_bus.mode == plpd_pkg::MODE_PIXEL);
      wr_fire       = req_fire && (req_bus.mode == plpd_pkg::MODE_WRITE);
      csr_fire      = csr_bus.valid && csr_bus.ready;
   end

   // Configuration registers; writes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         swap_ff     <= 1'b1;
      end else if (csr_fire) begin
         unique case (csr_bus.index)
            plpd_pkg::CSR_ORIGIN_X:      origin_x_ff <= csr_bus.data;
            plpd_pkg::CSR_ORIGIN_Y:      origin_y_ff <= csr_bus.data;
            plpd_pkg::CSR_SWAP_RED_BLUE: swap_ff     <= csr_bus.data[0];
            default: begin
            end
         endcase
      end
   end

   // Source position advances once per pixel and wraps at the end of the frame.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (pix_fire) begin
         if (col_ff == plpd_pkg::COL_LAST) begin
            col_in = '0;
            row_in = (row_ff == plpd_pkg::ROW_LAST) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Palette access for the accepted transaction.
   always_comb begin
      pal_req.wr_en = wr_fire;
      pal_req.rd_en = pix_fire;
      pal_req.index = req_bus.index;
      pal_req.color = req_bus.color;
   end

   plpd_palette u_palette (
      .clock    (clock),
      .reset    (reset),
      .pal_req  (pal_req),
      .rd_color (rd_color),
      .clearing (clearing)
   );

   // Lookup stage: block origin computed beside the palette read.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (pix_fire) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_fire) begin
         s1_bx_ff <= origin_x_ff + {col_ff, 1'b0};
         s1_by_ff <= origin_y_ff + plpd_pkg::COORD_W'({row_ff, 1'b0});
      end
   end

   always_comb begin
      blk.base_x = s1_bx_ff;
      blk.base_y = s1_by_ff;
      blk.color  = rd_color;
      blk.swap   = swap_ff;
   end

   plpd_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .blk      (blk),
      .load_en  (s1_move),
      .can_load (emit_can_load),
      .rsp_bus  (rsp_bus)
   );

   `PLPD_ASSERT(a_no_req_while_clearing, req_fire |-> !clearing, "transaction during clearing")
   `PLPD_ASSERT(a_col_in_frame, col_ff <= plpd_pkg::COL_LAST, "source column beyond frame")
   `PLPD_ASSERT_NEXT(a_pixel_enters_lookup, pix_fire, s1_valid_ff, "pixel lost before lookup")
   `PLPD_ASSERT_NEXT(a_write_keeps_position, wr_fire,
                     col_ff == $past(col_ff) && row_ff == $past(row_ff),
                     "palette write moved the source position")

endmodule

`default_nettype wire
